// ===== hw/rtl/bfsp_pkg.sv =====
// ============================================================================
// bfsp_pkg: shared types and constants for the shortest-path engine
// Field widths, item kinds, result codes and controller states.
// ============================================================================
package bfsp_pkg;

    localparam int VTX_W  = 8;
    localparam int WGT_W  = 16;
    localparam int DIST_W = 32;
    localparam int VCNT_W = 9;

    localparam logic [VCNT_W-1:0] VCNT_RESET = 9'd256;

    typedef enum logic [1:0] {
        KIND_ADD   = 2'd0,
        KIND_RUN   = 2'd1,
        KIND_QUERY = 2'd2,
        KIND_CLEAR = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        RES_OK        = 2'd0,
        RES_NEG_CYCLE = 2'd1,
        RES_QUERY     = 2'd2,
        RES_FULL      = 2'd3
    } code_t;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_EDGE  = 5'b00010,
        S_VRD   = 5'b00100,
        S_RELAX = 5'b01000,
        S_QUERY = 5'b10000
    } state_t;

    typedef struct packed {
        logic [VTX_W-1:0]        tail;
        logic [VTX_W-1:0]        head;
        logic signed [WGT_W-1:0] weight;
    } edge_t;

    typedef struct packed {
        logic signed [DIST_W-1:0] cost;
        logic [VTX_W-1:0]         parent;
    } vrec_t;

endpackage

// ===== hw/rtl/bfsp_in_if.sv =====
// ============================================================================
// bfsp_in_if: request channel
// Valid/ready channel carrying one command beat.
// ============================================================================
interface bfsp_in_if;
    logic              valid;
    logic              ready;
    logic [1:0]        kind;
    logic [7:0]        from_vertex;
    logic [7:0]        to_vertex;
    logic signed [15:0] edge_weight;
    logic [7:0]        vertex;

    modport source (output valid, kind, from_vertex, to_vertex, edge_weight, vertex,
                    input ready);
    modport sink   (input valid, kind, from_vertex, to_vertex, edge_weight, vertex,
                    output ready);
endinterface

// ===== hw/rtl/bfsp_out_if.sv =====
// ============================================================================
// bfsp_out_if: response channel
// Valid/ready channel carrying one result beat.
// ============================================================================
interface bfsp_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         result_code;
    logic signed [31:0] distance;
    logic               reachable;
    logic [7:0]         predecessor;
    logic               has_predecessor;

    modport source (output valid, result_code, distance, reachable, predecessor,
                    has_predecessor, input ready);
    modport sink   (input valid, result_code, distance, reachable, predecessor,
                    has_predecessor, output ready);
endinterface

// ===== hw/rtl/bfsp_cfg_if.sv =====
// ============================================================================
// bfsp_cfg_if: configuration write channel
// Valid/ready channel carrying the vertex count register value.
// ============================================================================
interface bfsp_cfg_if;
    logic       valid;
    logic       ready;
    logic [8:0] vertex_count;

    modport source (output valid, vertex_count, input ready);
    modport sink   (input valid, vertex_count, output ready);
endinterface

// ===== hw/rtl/bfsp_ram.sv =====
// ============================================================================
// bfsp_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ============================================================================
module bfsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ===== hw/rtl/bellman_ford_shortest_path.sv =====
// ============================================================================
// bellman_ford_shortest_path: single-source shortest paths over an edge list
// Edge store, vertex store and a read-modify-write relaxation controller.
// ============================================================================
// Edge-add and clear beats are taken one per cycle while idle and the
// output register allows; an edge beat against a full store returns a
// "full" result. A query does one vertex-memory read. A run clears the
// reached/parent flags, seeds the source, then relaxes every loaded edge
// once per pass for n-1 passes, n being the active vertex count, plus a
// final check pass. Each edge goes through an edge-memory read, then
// two vertex-memory reads (head and tail, from two mirrored copies), then
// compare and write-back. The check pass ends at the first edge that still
// improves (a negative cycle); a run with no edges loaded or with the
// source outside the active range returns OK without relaxing. Edges never
// overlap in flight, so a write always lands before the next read of the
// same vertex. Results leave through an output register; a new beat is
// taken in idle once that register is free or being drained.
// ============================================================================
module bellman_ford_shortest_path
    import bfsp_pkg::*;
#(
    parameter int MAX_VERTICES = 256,
    parameter int MAX_EDGES    = 1024
) (
    input logic      clk,
    input logic      rst_n,
    bfsp_in_if.sink  req,
    bfsp_out_if.source rsp,
    bfsp_cfg_if.sink cfg
);
    localparam int VAW  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int NCW  = $clog2(MAX_VERTICES + 1);
    localparam int CMPW = (NCW > VCNT_W) ? NCW : VCNT_W;
    localparam int EAW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ECW  = $clog2(MAX_EDGES + 1);
    localparam int EW   = $bits(edge_t);
    localparam int VW   = $bits(vrec_t);

    // Control and status registers
    state_t                    state_reg, state_next;
    logic [VCNT_W-1:0]         vcount_reg;
    logic [ECW-1:0]            edges_reg, edges_next;
    logic [ECW-1:0]            idx_reg, idx_next;
    logic [NCW-1:0]            pass_reg, pass_next;
    logic [NCW-1:0]            n_reg, n_next;
    logic [MAX_VERTICES-1:0]   reached_reg, reached_next;
    logic [MAX_VERTICES-1:0]   hp_reg, hp_next;

    // Per-edge working registers
    logic [VTX_W-1:0]          tail_reg, tail_next;
    logic signed [WGT_W-1:0]   wgt_reg, wgt_next;
    logic [VAW-1:0]            head_reg, head_next;
    logic                      ok_reg, ok_next;     // edge in range, tail reached
    logic                      rv_reg, rv_next;     // head already reached
    logic                      qr_reg, qr_next;
    logic                      qhp_reg, qhp_next;

    // Output register
    logic                      ov_reg, ov_next;
    code_t                     ocode_reg, ocode_next;
    logic signed [DIST_W-1:0]  odist_reg, odist_next;
    logic                      oreach_reg, oreach_next;
    logic [VTX_W-1:0]          opred_reg, opred_next;
    logic                      ohp_reg, ohp_next;

    // Memory ports
    logic                      e_we;
    logic [EAW-1:0]            e_waddr, e_raddr;
    logic [EW-1:0]             e_wdata, e_rdata;
    logic                      v_we;
    logic [VAW-1:0]            v_waddr, va_raddr, vb_raddr;
    logic [VW-1:0]             v_wdata, va_rdata, vb_rdata;

    edge_t                     e_rd;
    vrec_t                     va_rd, vb_rd;
    logic [CMPW-1:0]           vc_ext, n_act;
    logic                      in_acc;
    logic                      check_pass, last_edge, improve;
    logic signed [DIST_W:0]    sum;
    logic signed [DIST_W-1:0]  cand;

    bfsp_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_edge_ram (
        .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
        .raddr(e_raddr), .rdata(e_rdata)
    );

    // Two mirrored vertex stores: tail and head of one edge read together.
    bfsp_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_vtx_ram_a (
        .clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
        .raddr(va_raddr), .rdata(va_rdata)
    );

    bfsp_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_vtx_ram_b (
        .clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
        .raddr(vb_raddr), .rdata(vb_rdata)
    );

    assign e_rd  = edge_t'(e_rdata);
    assign va_rd = vrec_t'(va_rdata);
    assign vb_rd = vrec_t'(vb_rdata);

    assign req.ready = (state_reg == S_IDLE) && (!ov_reg || rsp.ready);
    assign in_acc    = req.valid && req.ready;
    assign cfg.ready = 1'b1;

    assign rsp.valid           = ov_reg;
    assign rsp.result_code     = ocode_reg;
    assign rsp.distance        = odist_reg;
    assign rsp.reachable       = oreach_reg;
    assign rsp.predecessor     = opred_reg;
    assign rsp.has_predecessor = ohp_reg;

    // Active vertex count: 0 counts as 1, clipped to the store size.
    assign vc_ext = CMPW'(vcount_reg);
    always_comb
    begin
        if (vc_ext == '0)
        begin
            n_act = CMPW'(1);
        end
        else if (vc_ext > CMPW'(MAX_VERTICES))
        begin
            n_act = CMPW'(MAX_VERTICES);
        end
        else
        begin
            n_act = vc_ext;
        end
    end

    // Saturating tail distance plus weight
    assign sum = {va_rd.cost[DIST_W-1], va_rd.cost}
               + {{(DIST_W + 1 - WGT_W){wgt_reg[WGT_W-1]}}, wgt_reg};
    always_comb
    begin
        if (sum[DIST_W] != sum[DIST_W-1])
        begin
            cand = sum[DIST_W] ? {1'b1, {(DIST_W-1){1'b0}}} : {1'b0, {(DIST_W-1){1'b1}}};
        end
        else
        begin
            cand = sum[DIST_W-1:0];
        end
    end

    assign check_pass = (pass_reg == n_reg);
    assign last_edge  = (idx_reg == edges_reg - ECW'(1));
    assign improve    = ok_reg && (!rv_reg || (vb_rd.cost > cand));
    assign e_raddr    = idx_reg[EAW-1:0];

    always_comb
    begin
        state_t s;
        s            = state_reg;
        edges_next   = edges_reg;
        idx_next     = idx_reg;
        pass_next    = pass_reg;
        n_next       = n_reg;
        reached_next = reached_reg;
        hp_next      = hp_reg;
        tail_next    = tail_reg;
        head_next    = head_reg;
        wgt_next     = wgt_reg;
        ok_next      = ok_reg;
        rv_next      = rv_reg;
        qr_next      = qr_reg;
        qhp_next     = qhp_reg;
        ov_next      = ov_reg;
        ocode_next   = ocode_reg;
        odist_next   = odist_reg;
        oreach_next  = oreach_reg;
        opred_next   = opred_reg;
        ohp_next     = ohp_reg;
        e_we         = 1'b0;
        e_waddr      = edges_reg[EAW-1:0];
        e_wdata      = {req.from_vertex, req.to_vertex, req.edge_weight};
        v_we         = 1'b0;
        v_waddr      = head_reg;
        v_wdata      = {cand, tail_reg};
        va_raddr     = '0;
        vb_raddr     = '0;

        if (rsp.valid && rsp.ready)
        begin
            ov_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    case (kind_t'(req.kind))
                        KIND_ADD:
                        begin
                            if (edges_reg >= ECW'(MAX_EDGES))
                            begin
                                ov_next     = 1'b1;
                                ocode_next  = RES_FULL;
                                odist_next  = '0;
                                oreach_next = 1'b0;
                                opred_next  = '0;
                                ohp_next    = 1'b0;
                            end
                            else
                            begin
                                e_we       = 1'b1;
                                edges_next = edges_reg + ECW'(1);
                            end
                        end
                        KIND_CLEAR:
                        begin
                            edges_next = '0;
                        end
                        KIND_QUERY:
                        begin
                            va_raddr = VAW'(CMPW'(req.vertex));
                            if (CMPW'(req.vertex) < CMPW'(MAX_VERTICES))
                            begin
                                qr_next  = reached_reg[VAW'(CMPW'(req.vertex))];
                                qhp_next = hp_reg[VAW'(CMPW'(req.vertex))];
                            end
                            else
                            begin
                                qr_next  = 1'b0;
                                qhp_next = 1'b0;
                            end
                            s = S_QUERY;
                        end
                        KIND_RUN:
                        begin
                            n_next       = NCW'(n_act);
                            reached_next = '0;
                            hp_next      = '0;
                            if ((CMPW'(req.vertex) >= n_act) || (edges_reg == '0))
                            begin
                                // Nothing to relax: no negative cycle possible.
                                if (CMPW'(req.vertex) < n_act)
                                begin
                                    reached_next[VAW'(CMPW'(req.vertex))] = 1'b1;
                                    v_we = 1'b1;
                                end
                                ov_next     = 1'b1;
                                ocode_next  = RES_OK;
                                odist_next  = '0;
                                oreach_next = 1'b0;
                                opred_next  = '0;
                                ohp_next    = 1'b0;
                            end
                            else
                            begin
                                reached_next[VAW'(CMPW'(req.vertex))] = 1'b1;
                                v_we      = 1'b1;
                                pass_next = NCW'(1);
                                idx_next  = '0;
                                s         = S_EDGE;
                            end
                            v_waddr = VAW'(CMPW'(req.vertex));
                            v_wdata = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_EDGE:
            begin
                s = S_VRD;
            end
            S_VRD:
            begin
                tail_next = e_rd.tail;
                head_next = VAW'(CMPW'(e_rd.head));
                wgt_next  = e_rd.weight;
                va_raddr  = VAW'(CMPW'(e_rd.tail));
                vb_raddr  = VAW'(CMPW'(e_rd.head));
                ok_next   = (CMPW'(e_rd.tail) < CMPW'(n_reg))
                         && (CMPW'(e_rd.head) < CMPW'(n_reg))
                         && reached_reg[VAW'(CMPW'(e_rd.tail))];
                rv_next   = reached_reg[VAW'(CMPW'(e_rd.head))];
                s         = S_RELAX;
            end
            S_RELAX:
            begin
                if (check_pass)
                begin
                    if (improve || last_edge)
                    begin
                        ov_next     = 1'b1;
                        ocode_next  = improve ? RES_NEG_CYCLE : RES_OK;
                        odist_next  = '0;
                        oreach_next = 1'b0;
                        opred_next  = '0;
                        ohp_next    = 1'b0;
                        s           = S_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + ECW'(1);
                        s        = S_EDGE;
                    end
                end
                else
                begin
                    if (improve)
                    begin
                        v_we                   = 1'b1;
                        reached_next[head_reg] = 1'b1;
                        hp_next[head_reg]      = 1'b1;
                    end
                    if (last_edge)
                    begin
                        pass_next = pass_reg + NCW'(1);
                        idx_next  = '0;
                    end
                    else
                    begin
                        idx_next = idx_reg + ECW'(1);
                    end
                    s = S_EDGE;
                end
            end
            S_QUERY:
            begin
                ov_next     = 1'b1;
                ocode_next  = RES_QUERY;
                odist_next  = qr_reg ? va_rd.cost : '0;
                oreach_next = qr_reg;
                opred_next  = qhp_reg ? va_rd.parent : '0;
                ohp_next    = qhp_reg;
                s           = S_IDLE;
            end
            default:
            begin
                s = S_IDLE;
            end
        endcase
        state_next = s;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            vcount_reg  <= VCNT_RESET;
            edges_reg   <= '0;
            idx_reg     <= '0;
            pass_reg    <= '0;
            n_reg       <= '0;
            reached_reg <= '0;
            hp_reg      <= '0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            edges_reg   <= edges_next;
            idx_reg     <= idx_next;
            pass_reg    <= pass_next;
            n_reg       <= n_next;
            reached_reg <= reached_next;
            hp_reg      <= hp_next;
            ov_reg      <= ov_next;
            if (cfg.valid && cfg.ready)
            begin
                vcount_reg <= cfg.vertex_count;
            end
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        tail_reg   <= tail_next;
        head_reg   <= head_next;
        wgt_reg    <= wgt_next;
        ok_reg     <= ok_next;
        rv_reg     <= rv_next;
        qr_reg     <= qr_next;
        qhp_reg    <= qhp_next;
        ocode_reg  <= ocode_next;
        odist_reg  <= odist_next;
        oreach_reg <= oreach_next;
        opred_reg  <= opred_next;
        ohp_reg    <= ohp_next;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !req.ready)
        else $error("request taken while a run or query is in flight");

    a_edge_count: assert property (@(posedge clk) disable iff (!rst_n)
        edges_reg <= ECW'(MAX_EDGES))
        else $error("edge count beyond store size");

    a_pass_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RELAX) |-> (pass_reg != '0) && (pass_reg <= n_reg))
        else $error("pass counter out of range");

    a_run_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.result_code != RES_QUERY))
            |-> (rsp.distance == '0) && !rsp.reachable && !rsp.has_predecessor)
        else $error("non-query result carries vertex data");

endmodule

// ===== bench/tb_bellman_ford_shortest_path.sv =====
// ============================================================================
// tb_bellman_ford_shortest_path: self-checking bench for the shortest-path engine
// Drives edge loads, runs, queries and clears through the request channel,
// predicts every result beat from a behavioral model of the relaxation passes
// and compares each response field by field, under several idle/stall mixes.
// ============================================================================
module tb_bellman_ford_shortest_path
    import bfsp_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NV        = 256;
    localparam int NE        = 1024;
    localparam int SETTLE    = 40;        // cycles after last result before config
    localparam longint LIMIT = 20000000;  // cycle budget for the whole run

    typedef struct {
        code_t              code;
        logic signed [31:0] cost;
        logic               reach;
        logic [7:0]         pred;
        logic               has_pred;
    } answer_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    bfsp_in_if  req ();
    bfsp_out_if rsp ();
    bfsp_cfg_if cfg ();

    bellman_ford_shortest_path uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source),
        .cfg   (cfg.sink)
    );

    always #1 clk = ~clk;

    // ---------------------------------------------------------------------
    // Shadow of the engine: edge list, vertex records, vertex count register
    // ---------------------------------------------------------------------
    logic [7:0]         g_tail   [NE];
    logic [7:0]         g_head   [NE];
    logic signed [15:0] g_weight [NE];
    int                 g_edges;
    logic signed [31:0] v_dist   [NV];
    bit                 v_reach  [NV];
    logic [7:0]         v_par    [NV];
    bit                 v_haspar [NV];
    logic [8:0]         vcount_reg;

    answer_t pending_answers[$];
    int      mismatches;
    int      beats_sent;
    int      idle_pct;   // sender gap probability, percent
    int      stall_pct;  // receiver stall probability, percent

    function automatic int active_vertices();
        if (vcount_reg == 0)
            return 1;
        if (vcount_reg > NV)
            return NV;
        return vcount_reg;
    endfunction

    function automatic logic signed [31:0] clamp_sum(logic signed [31:0] a,
                                                     logic signed [15:0] w);
        longint s;
        s = longint'(a) + longint'(w);
        if (s > 64'sd2147483647)
            return 32'sh7fffffff;
        if (s < -64'sd2147483648)
            return 32'sh80000000;
        return s[31:0];
    endfunction

    // One relaxation attempt on edge i; true if the head would improve.
    function automatic bit relax_edge(int i, int n, bit apply);
        int u;
        int v;
        logic signed [31:0] cand;
        u = g_tail[i];
        v = g_head[i];
        if (u >= n || v >= n)
            return 0;
        // unreached tail: no sum with "infinity"
        if (!v_reach[u])
            return 0;
        cand = clamp_sum(v_dist[u], g_weight[i]);
        if (v_reach[v] && v_dist[v] <= cand)
            return 0;
        if (apply)
        begin
            v_dist[v]   = cand;
            v_reach[v]  = 1;
            v_par[v]    = u[7:0];
            v_haspar[v] = 1;
        end
        return 1;
    endfunction

    // Full run: passes over the loaded edges, then the negative-cycle check.
    function automatic bit shortest_paths_from(int src);
        int n;
        n = active_vertices();
        for (int k = 0; k < NV; k++)
        begin
            v_reach[k]  = 0;
            v_haspar[k] = 0;
        end
        if (src >= n)
            return 0;
        v_dist[src]  = 0;
        v_reach[src] = 1;
        for (int p = 1; p < n; p++)
            for (int i = 0; i < g_edges; i++)
                void'(relax_edge(i, n, 1));
        for (int i = 0; i < g_edges; i++)
            if (relax_edge(i, n, 0))
                return 1;
        return 0;
    endfunction

    // Apply one accepted request beat to the shadow and queue its answer, if any.
    function automatic void predict_beat(kind_t k, logic [7:0] fv, logic [7:0] tv,
                                         logic signed [15:0] w, logic [7:0] vx);
        answer_t a;
        a = '{code: RES_OK, cost: 0, reach: 0, pred: 0, has_pred: 0};
        case (k)
            KIND_ADD:
            begin
                if (g_edges >= NE)
                begin
                    a.code = RES_FULL;
                    pending_answers.push_back(a);
                end
                else
                begin
                    g_tail[g_edges]   = fv;
                    g_head[g_edges]   = tv;
                    g_weight[g_edges] = w;
                    g_edges++;
                end
            end
            KIND_RUN:
            begin
                a.code = shortest_paths_from(vx) ? RES_NEG_CYCLE : RES_OK;
                pending_answers.push_back(a);
            end
            KIND_QUERY:
            begin
                a.code = RES_QUERY;
                if (v_reach[vx])
                begin
                    a.cost  = v_dist[vx];
                    a.reach = 1;
                end
                if (v_haspar[vx])
                begin
                    a.pred     = v_par[vx];
                    a.has_pred = 1;
                end
                pending_answers.push_back(a);
            end
            default:
                g_edges = 0;
        endcase
    endfunction

    task automatic report_mismatch(string msg);
        mismatches++;
        $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    // ---------------------------------------------------------------------
    // Request side: drive at falling edge, accept at rising edge
    // ---------------------------------------------------------------------
    task automatic send_beat(kind_t k, logic [7:0] fv = 0, logic [7:0] tv = 0,
                             logic signed [15:0] w = 0, logic [7:0] vx = 0);
        while ($urandom_range(99) < idle_pct)
        begin
            req.valid = 1'b0;
            @(negedge clk);
        end
        req.valid       = 1'b1;
        req.kind        = k;
        req.from_vertex = fv;
        req.to_vertex   = tv;
        req.edge_weight = w;
        req.vertex      = vx;
        do
            @(posedge clk);
        while (!req.ready);
        predict_beat(k, fv, tv, w, vx);
        beats_sent++;
        @(negedge clk);
        req.valid = 1'b0;
    endtask

    task automatic add_edge(int fv, int tv, int w);
        send_beat(KIND_ADD, fv[7:0], tv[7:0], w[15:0], 0);
    endtask

    task automatic run_from(int src);
        send_beat(KIND_RUN, 0, 0, 0, src[7:0]);
    endtask

    task automatic query_vertex(int vx);
        send_beat(KIND_QUERY, 0, 0, 0, vx[7:0]);
    endtask

    task automatic clear_edges();
        send_beat(KIND_CLEAR);
    endtask

    // Drain outstanding answers and let add/clear beats retire.
    task automatic wait_idle();
        while (pending_answers.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic set_vertex_count(int value);
        wait_idle();
        cfg.valid        = 1'b1;
        cfg.vertex_count = value[8:0];
        do
            @(posedge clk);
        while (!cfg.ready);
        vcount_reg = value[8:0];
        @(negedge clk);
        cfg.valid = 1'b0;
    endtask

    // ---------------------------------------------------------------------
    // Response side: random backpressure, check every accepted beat
    // ---------------------------------------------------------------------
    always @(negedge clk)
        rsp.ready <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (pending_answers.size() == 0)
                report_mismatch("result beat with nothing expected");
            else
            begin
                answer_t e;
                e = pending_answers.pop_front();
                if (rsp.result_code !== e.code)
                    report_mismatch($sformatf("result_code %0d exp %0d",
                                              rsp.result_code, e.code));
                if (rsp.distance !== e.cost)
                    report_mismatch($sformatf("distance %0d exp %0d",
                                              rsp.distance, e.cost));
                if (rsp.reachable !== e.reach)
                    report_mismatch($sformatf("reachable %0b exp %0b",
                                              rsp.reachable, e.reach));
                if (rsp.predecessor !== e.pred)
                    report_mismatch($sformatf("predecessor %0d exp %0d",
                                              rsp.predecessor, e.pred));
                if (rsp.has_predecessor !== e.has_pred)
                    report_mismatch($sformatf("has_predecessor %0b exp %0b",
                                              rsp.has_predecessor, e.has_pred));
            end
        end
    end

    // Watchdog
    longint cycles = 0;
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------

    // Fresh engine: nothing reached, then a run with no edges at full count.
    task automatic test_reset_state();
        query_vertex(0);
        query_vertex(255);
        run_from(0);
        query_vertex(0);
        query_vertex(1);
    endtask

    // Small graph with a shortcut and extreme weights.
    task automatic test_basic_paths();
        set_vertex_count(8);
        add_edge(0, 1, 32767);
        add_edge(1, 2, -32768);
        add_edge(0, 2, 5);
        add_edge(2, 3, 0);
        add_edge(5, 6, 1);      // unreached tail, must be skipped
        run_from(0);
        for (int v = 0; v < 7; v++)
            query_vertex(v);
    endtask

    // Negative loop reachable from the source.
    task automatic test_negative_cycle();
        clear_edges();
        add_edge(0, 1, 2);
        add_edge(1, 2, -3);
        add_edge(2, 1, 1);
        run_from(0);
        query_vertex(2);
        run_from(3);            // loop not reachable from here
        query_vertex(3);
    endtask

    // Sources and edges outside the active range, count clamping.
    task automatic test_range_limits();
        clear_edges();
        add_edge(0, 3, 4);
        add_edge(3, 1, 1);
        add_edge(0, 255, 7);
        set_vertex_count(3);
        run_from(0);
        query_vertex(1);
        query_vertex(3);
        run_from(200);          // source beyond the count
        query_vertex(0);
        set_vertex_count(0);    // taken as one vertex
        run_from(0);
        query_vertex(0);
        set_vertex_count(511);  // taken as the maximum
        run_from(0);
        query_vertex(255);
        query_vertex(1);
        set_vertex_count(1);
        run_from(0);
    endtask

    // Fill the edge store, overflow it, run a tiny graph over the full list.
    task automatic test_store_full();
        set_vertex_count(2);
        clear_edges();
        for (int i = 0; i < NE; i++)
            add_edge($urandom_range(3), $urandom_range(3), $urandom_range(65535));
        add_edge(1, 0, -1);     // rejected
        add_edge(255, 255, 0);  // rejected
        run_from(0);
        query_vertex(1);
        clear_edges();
        run_from(1);
        query_vertex(1);
    endtask

    // Random graphs under one idle/stall mix.
    task automatic test_random_graphs(int sender_idle, int receiver_stall, int beats);
        int n;
        int target;
        int ne;
        int w;
        idle_pct  = sender_idle;
        stall_pct = receiver_stall;
        target    = beats_sent + beats;
        n         = $urandom_range(2, 12);
        set_vertex_count(n);
        while (beats_sent < target)
        begin
            clear_edges();
            ne = $urandom_range(0, 24);
            for (int i = 0; i < ne; i++)
            begin
                if ($urandom_range(9) == 0)
                    w = $urandom_range(65535);               // full-range noise
                else if ($urandom_range(3) == 0)
                    w = -$urandom_range(1, 6);
                else
                    w = $urandom_range(0, 40);
                if ($urandom_range(15) == 0)
                    add_edge($urandom_range(255), $urandom_range(255), w);
                else
                    add_edge($urandom_range(n - 1), $urandom_range(n - 1), w);
            end
            run_from(($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(n - 1));
            repeat ($urandom_range(1, 6))
                query_vertex(($urandom_range(7) == 0) ? $urandom_range(255)
                                                      : $urandom_range(n - 1));
            if ($urandom_range(5) == 0)
                send_beat(kind_t'($urandom_range(3)), $urandom_range(255),
                          $urandom_range(255), $urandom_range(65535), $urandom_range(255));
        end
    endtask

    initial
    begin
        mismatches       = 0;
        beats_sent       = 0;
        idle_pct         = 0;
        stall_pct        = 0;
        g_edges          = 0;
        vcount_reg       = VCNT_RESET;
        req.valid        = 1'b0;
        req.kind         = KIND_ADD;
        req.from_vertex  = '0;
        req.to_vertex    = '0;
        req.edge_weight  = '0;
        req.vertex       = '0;
        rsp.ready        = 1'b0;
        cfg.valid        = 1'b0;
        cfg.vertex_count = '0;
        for (int k = 0; k < NV; k++)
        begin
            v_reach[k]  = 0;
            v_haspar[k] = 0;
            v_dist[k]   = 0;
            v_par[k]    = 0;
        end
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_state();
        test_basic_paths();
        test_negative_cycle();
        test_range_limits();
        test_store_full();
        test_random_graphs(0, 0, 170);
        test_random_graphs(73, 0, 170);
        test_random_graphs(0, 73, 170);
        test_random_graphs(24, 24, 170);
        idle_pct  = 0;
        stall_pct = 0;

        while (pending_answers.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
